FILE: design/b64enc_pkg.sv
// Package for the base64 stream encoder: group record type, pad character,
// and the sextet-to-character alphabet function. No dependencies.
package b64enc_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;   // '='

	localparam logic [1:0] PAD_NONE = 2'd0;
	localparam logic [1:0] PAD_ONE  = 2'd1;
	localparam logic [1:0] PAD_TWO  = 2'd2;

	// One group of up to three bytes, ready to be spelled out as four characters
	typedef struct packed {
		logic [23:0] group;
		logic [1:0]  pad_cnt;   // trailing '=' characters
		logic        last;      // group closes the message
	} b64enc_group_t;

	// Standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [7:0] b64_char(input logic [5:0] sextet);
		logic [7:0] s8;
		logic [7:0] ch;
		s8 = {2'b00, sextet};
		if (sextet < 6'd26) begin
			ch = 8'(8'h41 + s8);
		end else if (sextet < 6'd52) begin
			ch = 8'(8'h61 + s8 - 8'd26);
		end else if (sextet < 6'd62) begin
			ch = 8'(8'h30 + s8 - 8'd52);
		end else if (sextet == 6'd62) begin
			ch = 8'h2B;
		end else begin
			ch = 8'h2F;
		end
		return ch;
	endfunction

endpackage

FILE: design/b64enc_byte_if.sv
// Byte channel interface: valid/ready handshake carrying one raw byte and
// the end-of-message flag. No dependencies.
interface b64enc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       is_final;

	modport source (output valid, output data_byte, output is_final, input ready);
	modport sink (input valid, input data_byte, input is_final, output ready);
endinterface

FILE: design/b64enc_char_if.sv
// Character channel interface: valid/ready handshake carrying one encoded
// character and its end-of-text mark. No dependencies.
interface b64enc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_char;
	logic       end_of_text;

	modport source (output valid, output code_char, output end_of_text, input ready);
	modport sink (input valid, input code_char, input end_of_text, output ready);
endinterface

FILE: design/base64_stream_encoder_unit.sv
// Top level of the base64 stream encoder: front end, group queue, back end.
// Depends on b64enc_pkg, b64enc_byte_if, b64enc_char_if and the submodules.
//
// Base64 (standard alphabet, '=' padding) encoder for a byte stream. Bytes
// arrive on raw with is_final on the last byte of each message; characters
// leave on code with end_of_text on the last character of each message.
// Bytes are taken one per cycle while the two-entry group queue has room;
// every group of three bytes, and every short tail closed by a final byte,
// gives four characters, sent one per cycle from a registered output while
// the character port takes them, so the character port sets the sustained
// rate. With the back end idle, the group completed by an accepted byte is
// written into the group queue, and its first character is then loaded into
// the output register before it is offered.
module base64_stream_encoder_unit (
	input  logic          clk,
	input  logic          arst_n,
	b64enc_byte_if.sink   raw,
	b64enc_char_if.source code
);
	import b64enc_pkg::*;

	logic          push_valid;
	logic          push_ready;
	b64enc_group_t push_entry;
	logic          pop_valid;
	logic          pop_ready;
	b64enc_group_t pop_entry;

	b64enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.raw        (raw),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	b64enc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop_ready  (pop_ready)
	);

	b64enc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop_ready (pop_ready),
		.code      (code)
	);
endmodule

FILE: design/b64enc_front.sv
// Front end: accepts raw bytes, holds the pending tail and forms groups.
// Depends on b64enc_pkg and b64enc_byte_if.
module b64enc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	b64enc_byte_if.sink             raw,
	output logic                    push_valid,
	output b64enc_pkg::b64enc_group_t push_entry,
	input  logic                    push_ready
);
	import b64enc_pkg::*;

	logic [15:0] held_q;
	logic [1:0]  cnt_q;
	logic [1:0]  cnt;
	logic        accept;

	// count value three never occurs; it reads as empty
	assign cnt    = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
	assign raw.ready = push_ready;
	assign accept = raw.valid && raw.ready;
	assign push_valid = accept && ((cnt == 2'd2) || raw.is_final);

	// group assembly
	always_comb begin
		push_entry.last = raw.is_final;
		if (cnt == 2'd2) begin
			push_entry.group   = {held_q, raw.data_byte};
			push_entry.pad_cnt = PAD_NONE;
		end else if (cnt == 2'd1) begin
			push_entry.group   = {held_q[15:8], raw.data_byte, 8'h00};
			push_entry.pad_cnt = PAD_ONE;
		end else begin
			push_entry.group   = {raw.data_byte, 16'h0000};
			push_entry.pad_cnt = PAD_TWO;
		end
	end

	// pending bytes and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			cnt_q  <= '0;
		end else if (accept) begin
			if (push_valid) begin
				held_q <= '0;
				cnt_q  <= '0;
			end else if (cnt == 2'd0) begin
				held_q <= {raw.data_byte, 8'h00};
				cnt_q  <= 2'd1;
			end else begin
				held_q <= {held_q[15:8], raw.data_byte};
				cnt_q  <= 2'd2;
			end
		end
	end
endmodule

FILE: design/b64enc_queue.sv
// Two-entry group queue between the front end and the character back end.
// Depends on b64enc_pkg.
module b64enc_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push_valid,
	input  b64enc_pkg::b64enc_group_t push_entry,
	output logic                      push_ready,
	output logic                      pop_valid,
	output b64enc_pkg::b64enc_group_t pop_entry,
	input  logic                      pop_ready
);
	import b64enc_pkg::*;

	b64enc_group_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= 2'(fill_q + 2'd1);
			end else if (do_pop && !do_push) begin
				fill_q <= 2'(fill_q - 2'd1);
			end
		end
	end
endmodule

FILE: design/b64enc_back.sv
// Back end: spells each queued group as four characters, one per cycle while
// code.ready holds, through an output register. Depends on b64enc_pkg and b64enc_char_if.
module b64enc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pop_valid,
	input  b64enc_pkg::b64enc_group_t pop_entry,
	output logic                      pop_ready,
	b64enc_char_if.source             code
);
	import b64enc_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       out_end_q;
	logic       load;
	logic [5:0] sextet;
	logic       is_pad;
	logic [7:0] next_char;

	assign load      = pop_valid && (!out_valid_q || code.ready);
	assign pop_ready = load && (idx_q == 2'd3);

	// sextet selection and padding
	always_comb begin
		case (idx_q)
			2'd0:    sextet = pop_entry.group[23:18];
			2'd1:    sextet = pop_entry.group[17:12];
			2'd2:    sextet = pop_entry.group[11:6];
			default: sextet = pop_entry.group[5:0];
		endcase
		is_pad = ((pop_entry.pad_cnt == PAD_TWO) && idx_q[1])
			|| ((pop_entry.pad_cnt == PAD_ONE) && (idx_q == 2'd3));
		next_char = is_pad ? PAD_CHAR : b64_char(sextet);
	end

	// character position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= 2'(idx_q + 2'd1);
				out_valid_q <= 1'b1;
			end else if (code.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= next_char;
			out_end_q  <= (idx_q == 2'd3) && pop_entry.last;
		end
	end

	assign code.valid       = out_valid_q;
	assign code.code_char   = out_char_q;
	assign code.end_of_text = out_end_q;
endmodule
